// ----- hdl/csr_sparse_row_dot_engine_core_defines.svh -----
// Assertion macros used by the engine's multiply-accumulate stage.
`ifndef CSR_SPARSE_ROW_DOT_ENGINE_CORE_DEFINES_SVH
`define CSR_SPARSE_ROW_DOT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CSRD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csrd same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define CSRD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csrd next-cycle check failed");

`endif

// ----- hdl/csrd_pkg.sv -----
// Shared constants and types of the sparse row dot engine.
package csrd_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int VEC_AW       = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_NONZERO = 2'd1;
	localparam logic [1:0] ACT_EMPTY   = 2'd2;

	// What an item in flight still has to do at the accumulator.
	typedef struct packed {
		logic nz_ok;    // in-range nonzero: add the product
		logic col_err;  // nonzero with column outside the store
		logic emit;     // close the row after this item
	} item_ctl_t;

	// A finished row handed from the accumulator to the rounding stage.
	typedef struct packed {
		logic [63:0] acc;
		logic        sat;
		logic        err;
		logic [15:0] row;
	} row_fin_t;

endpackage

// ----- hdl/csrd_fetch.sv -----
// Input stage: vector store writes, column rebasing and the registered store read.
module csrd_fetch
	import csrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               item_valid,
	input  logic [1:0]         action,
	input  logic [15:0]        index,
	input  logic signed [31:0] value,
	input  logic               row_end,
	input  logic [15:0]        column_offset,
	output logic               v_s1,
	output item_ctl_t          ctl_s1,
	output logic signed [31:0] val_s1,
	output logic signed [31:0] vec_s1
);

	logic [31:0]       mem [VECTOR_DEPTH];
	logic              take;
	logic              is_load;
	logic              is_nz;
	logic              is_empty;
	logic              load_ok;
	logic [16:0]       diff;
	logic              col_bad;
	logic [VEC_AW-1:0] wr_addr;
	logic [VEC_AW-1:0] rd_addr;

	assign take     = item_valid && adv;
	assign is_load  = (action == ACT_LOAD);
	assign is_nz    = (action == ACT_NONZERO);
	assign is_empty = (action == ACT_EMPTY);
	assign load_ok  = ({1'b0, index} < 17'(VECTOR_DEPTH));
	assign diff     = {1'b0, index} - {1'b0, column_offset};
	assign col_bad  = (index < column_offset) || (diff >= 17'(VECTOR_DEPTH));
	assign wr_addr  = index[VEC_AW-1:0];
	assign rd_addr  = diff[VEC_AW-1:0];

	// Store port: a load writes, a nonzero reads; one item per edge, so no conflict.
	always_ff @(posedge clk) begin
		if (take && is_load && load_ok) begin
			mem[wr_addr] <= value;
		end
		if (take && is_nz) begin
			vec_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s1 <= '0;
		end else if (adv) begin
			// loads finish here; only nonzero and empty-row items go on
			v_s1           <= item_valid && (is_nz || is_empty);
			ctl_s1.nz_ok   <= is_nz && !col_bad;
			ctl_s1.col_err <= is_nz && col_bad;
			ctl_s1.emit    <= (is_nz && row_end) || is_empty;
		end
	end

endmodule

// ----- hdl/csrd_mac.sv -----
// Multiply stage and saturating row accumulator with row marks and row counter.
`include "csr_sparse_row_dot_engine_core_defines.svh"

module csrd_mac
	import csrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_s1,
	input  item_ctl_t          ctl_s1,
	input  logic signed [31:0] val_s1,
	input  logic signed [31:0] vec_s1,
	output logic               emit_pending,
	output logic               fin_valid,
	output row_fin_t           fin
);

	localparam logic [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] ACC_MIN = {1'b1, 63'd0};

	logic               v_s2;
	item_ctl_t          ctl_s2;
	logic signed [63:0] prod_s2;
	logic [63:0]        acc_q;
	logic               sat_q;
	logic               err_q;
	logic [15:0]        row_cnt_q;
	logic               consume;
	logic [64:0]        sum65;
	logic               ovf;
	logic [63:0]        acc_next;
	logic               sat_next;
	logic               err_next;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= val_s1 * vec_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			ctl_s2 <= '0;
		end else if (adv) begin
			v_s2   <= v_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	assign consume  = adv && v_s2;
	assign sum65    = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
	assign ovf      = sum65[64] ^ sum65[63];
	assign acc_next = !ctl_s2.nz_ok ? acc_q :
	                  ovf ? (sum65[64] ? ACC_MIN : ACC_MAX) : sum65[63:0];
	assign sat_next = sat_q || (ctl_s2.nz_ok && ovf);
	assign err_next = err_q || ctl_s2.col_err;

	assign emit_pending = v_s2 && ctl_s2.emit;
	assign fin_valid    = consume && ctl_s2.emit;
	assign fin.acc      = acc_next;
	assign fin.sat      = sat_next;
	assign fin.err      = err_next;
	assign fin.row      = row_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			sat_q     <= 1'b0;
			err_q     <= 1'b0;
			row_cnt_q <= '0;
		end else if (consume) begin
			if (ctl_s2.emit) begin
				// row closes: clear and advance
				acc_q     <= '0;
				sat_q     <= 1'b0;
				err_q     <= 1'b0;
				row_cnt_q <= row_cnt_q + 16'd1;
			end else begin
				acc_q <= acc_next;
				sat_q <= sat_next;
				err_q <= err_next;
			end
		end
	end

	`CSRD_ASSERT_NEXT(a_acc_clear, fin_valid, acc_q == '0 && !sat_q && !err_q)
	`CSRD_ASSERT_NEXT(a_row_adv, fin_valid, row_cnt_q == 16'($past(row_cnt_q) + 16'd1))
	`CSRD_ASSERT_NOW(a_ctl_excl, v_s2, !(ctl_s2.nz_ok && ctl_s2.col_err))

endmodule

// ----- hdl/csrd_round.sv -----
// Finished-row stage: round Q32.32 to Q16.16, saturate, and hold the result register.
module csrd_round
	import csrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fin_valid,
	input  row_fin_t           fin,
	output logic               s3_free,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [15:0]        row_number,
	output logic signed [31:0] row_sum,
	output logic               saturated,
	output logic               column_error
);

	logic        v_s3;
	row_fin_t    fin_s3;
	logic        move;
	logic [48:0] q;
	logic        over;
	logic        under;
	logic [31:0] sum_rnd;

	assign move    = v_s3 && (!result_valid || result_ready);
	assign s3_free = !v_s3 || move;

	// half rounds toward +infinity: floor(acc / 2^16) plus bit 15
	assign q       = {fin_s3.acc[63], fin_s3.acc[63:16]} + {48'd0, fin_s3.acc[15]};
	assign over    = !q[48] && (|q[47:31]);
	assign under   = q[48] && !(&q[47:31]);
	assign sum_rnd = over ? 32'h7FFF_FFFF : under ? 32'h8000_0000 : q[31:0];

	always_ff @(posedge clk) begin
		if (fin_valid) begin
			fin_s3 <= fin;
		end
		if (move) begin
			row_number   <= fin_s3.row;
			row_sum      <= sum_rnd;
			saturated    <= fin_s3.sat || over || under;
			column_error <= fin_s3.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (fin_valid) begin
				v_s3 <= 1'b1;
			end else if (move) begin
				v_s3 <= 1'b0;
			end
			if (move) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/csr_sparse_row_dot_engine_core.sv -----
// Sparse-matrix times dense-vector engine: CSR rows in, rounded row sums out.
//
// Takes one item per clock while item_ready is high. A load item writes a
// Q16.16 vector element into a 1024-entry on-chip store; a nonzero item
// rebases its column by column_offset, reads the store, multiplies by its
// Q16.16 value and adds the exact Q32.32 product into a saturating 64-bit row
// accumulator; a nonzero with row_end, or an empty-row item, closes the row.
// Throughput is one item per cycle while item_ready is high: the store has
// one port used once per item and the accumulator takes one product per
// cycle. A row's rounded result reaches the output register through the store
// read, product and finished-row registers; stalls can hold it. item_ready
// drops only when a closing item reaches the accumulator while the rounding
// stage and the output register both still hold rows that were not taken.
// Columns below column_offset or past the store add nothing and set
// column_error; loads past the store are dropped; action 3 does nothing.
// Entries of the store that were never loaded read as unknown data.
// column_offset may only be written while the engine is idle.
module csr_sparse_row_dot_engine_core
	import csrd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [1:0]         action,
	input  logic [15:0]        index,
	input  logic signed [31:0] value,
	input  logic               row_end,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [15:0]        row_number,
	output logic signed [31:0] row_sum,
	output logic               saturated,
	output logic               column_error
);

	logic [15:0]        column_offset_q;
	logic               adv;
	logic               v_s1;
	item_ctl_t          ctl_s1;
	logic signed [31:0] val_s1;
	logic signed [31:0] vec_s1;
	logic               emit_pending;
	logic               fin_valid;
	row_fin_t           fin;
	logic               s3_free;

	// configuration register; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= '0;
		end else if (cfg_wr_en) begin
			column_offset_q <= cfg_wr_data;
		end
	end

	// advance the front stages unless a closing row has nowhere to go
	assign adv        = !emit_pending || s3_free;
	assign item_ready = adv;

	csrd_fetch u_fetch (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.item_valid   (item_valid),
		.action       (action),
		.index        (index),
		.value        (value),
		.row_end      (row_end),
		.column_offset(column_offset_q),
		.v_s1         (v_s1),
		.ctl_s1       (ctl_s1),
		.val_s1       (val_s1),
		.vec_s1       (vec_s1)
	);

	csrd_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.v_s1        (v_s1),
		.ctl_s1      (ctl_s1),
		.val_s1      (val_s1),
		.vec_s1      (vec_s1),
		.emit_pending(emit_pending),
		.fin_valid   (fin_valid),
		.fin         (fin)
	);

	csrd_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.fin_valid   (fin_valid),
		.fin         (fin),
		.s3_free     (s3_free),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.row_number  (row_number),
		.row_sum     (row_sum),
		.saturated   (saturated),
		.column_error(column_error)
	);

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the CSR sparse row dot engine core.
module tb
	import csrd_pkg::*;
();

	// The one action code the package leaves unnamed; the engine drops it.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// One input item as the driver presents it.
	typedef struct packed {
		logic [1:0]  act;
		logic [15:0] idx;
		logic [31:0] val;
		logic        fin;
	} feed_item_t;

	// One finished row as the engine should report it.
	typedef struct {
		logic [15:0]        row;
		logic signed [31:0] sum;
		logic               sat;
		logic               err;
	} row_out_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [15:0]        cfg_wr_data  = '0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	logic [1:0]         action       = ACT_LOAD;
	logic [15:0]        index        = '0;
	logic signed [31:0] value        = '0;
	logic               row_end      = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [15:0]        row_number;
	logic signed [31:0] row_sum;
	logic               saturated;
	logic               column_error;

	// Items waiting for the driver, and rows waiting for the monitor.
	feed_item_t item_feed[$];
	row_out_t   rows_due[$];

	// Shadow of the engine: vector store, Q32.32 accumulator, row marks, offset.
	logic signed [31:0] vec_copy [VECTOR_DEPTH];
	logic signed [63:0] acc_q32   = '0;
	logic [15:0]        rows_done = '0;
	logic               sat_seen  = 1'b0;
	logic               err_seen  = 1'b0;
	logic [15:0]        col_base  = '0;

	// Generator side: which store entries the planned stream has loaded so far.
	// Nonzero items in range only read entries listed here, so none of them reads an unwritten entry.
	bit loaded [VECTOR_DEPTH];
	int loaded_list[$];

	int mismatches = 0;
	int gap_left   = 0;
	int burst_left = 0;
	int rdy_cyc    = 0;

	csr_sparse_row_dot_engine_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.action      (action),
		.index       (index),
		.value       (value),
		.row_end     (row_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.row_number  (row_number),
		.row_sum     (row_sum),
		.saturated   (saturated),
		.column_error(column_error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Round the accumulator to Q16.16 (half toward +infinity), clamp to 32 bits,
	// queue the expected row, then clear the row state and advance the counter.
	task automatic close_row();
		row_out_t           r;
		logic signed [64:0] biased;
		logic signed [48:0] q16;
		r.row  = rows_done;
		r.sat  = sat_seen;
		r.err  = err_seen;
		biased = acc_q32 + 65'sd32768;
		q16    = 49'(biased >>> 16);
		if (q16 > 49'sd2147483647) begin
			r.sum = 32'h7FFF_FFFF;
			r.sat = 1'b1;
		end else if (q16 < -49'sd2147483648) begin
			r.sum = 32'h8000_0000;
			r.sat = 1'b1;
		end else begin
			r.sum = q16[31:0];
		end
		rows_due.insert(rows_due.size(), r);
		acc_q32   = '0;
		sat_seen  = 1'b0;
		err_seen  = 1'b0;
		rows_done = rows_done + 16'd1;
	endtask

	// Advance the shadow by one accepted item.
	task automatic apply_item(input logic [1:0] act, input logic [15:0] idx,
			input logic signed [31:0] val, input logic fin);
		int                 pos;
		logic signed [63:0] prod;
		logic signed [64:0] wide;
		case (act)
			ACT_LOAD: begin
				if (idx < VECTOR_DEPTH)
					vec_copy[idx] = val;
			end
			ACT_NONZERO: begin
				pos = int'(idx) - int'(col_base);
				if (pos < 0 || pos >= VECTOR_DEPTH) begin
					err_seen = 1'b1;
				end else begin
					prod = longint'(val) * longint'(vec_copy[pos]);
					wide = acc_q32 + prod;
					// Clamp on signed overflow of the 64-bit sum.
					if (wide[64] != wide[63]) begin
						sat_seen = 1'b1;
						acc_q32  = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					end else begin
						acc_q32 = wide[63:0];
					end
				end
				if (fin)
					close_row();
			end
			ACT_EMPTY: close_row();
			default: ;
		endcase
	endtask

	// Driver: record each accepted item in the shadow, then present the next one.
	// Items go out in bursts of random length with random gaps between them;
	// valid holds with its payload until the engine takes the item.
	always @(posedge clk) begin
		feed_item_t nxt;
		if (arst_n) begin
			if (item_valid && item_ready)
				apply_item(action, index, value, row_end);
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (item_feed.size() > 0) begin
					nxt = item_feed.pop_front();
					item_valid <= 1'b1;
					action     <= nxt.act;
					index      <= nxt.idx;
					value      <= nxt.val;
					row_end    <= nxt.fin;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 7) == 0) begin
						// a long stretch with no gaps at all
						burst_left = $urandom_range(40, 90);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted row with the oldest expected one.
	// The receiver cycles through four stall modes in turn:
	// always ready, coin flip, mostly stalled, and a fixed 2-of-5 pattern.
	always @(posedge clk) begin
		row_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (rows_due.size() == 0) begin
				$error("row %0d arrived with no row due", row_number);
				mismatches++;
			end else begin
				want = rows_due.pop_front();
				if (row_number !== want.row) begin
					$error("row_number: expected %0d, got %0d", want.row, row_number);
					mismatches++;
				end
				if (row_sum !== want.sum) begin
					$error("row_sum: expected %0d, got %0d", want.sum, row_sum);
					mismatches++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, saturated);
					mismatches++;
				end
				if (column_error !== want.err) begin
					$error("column_error: expected %0b, got %0b", want.err, column_error);
					mismatches++;
				end
			end
		end
		rdy_cyc++;
		case ((rdy_cyc / 256) % 4)
			0: result_ready <= 1'b1;
			1: result_ready <= 1'($urandom_range(0, 1));
			2: result_ready <= ($urandom_range(0, 3) == 0);
			default: result_ready <= ((rdy_cyc % 5) < 2);
		endcase
	end

	// Plan one item and track which store entries it loads.
	task automatic queue_item(input logic [1:0] act, input logic [15:0] idx,
			input logic [31:0] val, input logic fin);
		feed_item_t it;
		it.act = act;
		it.idx = idx;
		it.val = val;
		it.fin = fin;
		item_feed.insert(item_feed.size(), it);
		if (act == ACT_LOAD && idx < VECTOR_DEPTH && !loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_list.insert(loaded_list.size(), int'(idx));
		end
	endtask

	// Q16.16 operand: mostly modest magnitudes so sums stay in range,
	// with full-width values and the extremes mixed in.
	function automatic logic [31:0] rand_q16();
		logic [31:0] mag;
		case ($urandom_range(0, 19))
			17: return 32'h7FFF_FFFF;
			18: return 32'h8000_0000;
			19: return ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: begin
				if ($urandom_range(0, 19) > 11)
					return $urandom;
				mag = $urandom_range(0, 32'h3FFFF);
				return ($urandom_range(0, 1) != 0) ? -mag : mag;
			end
		endcase
	endfunction

	// Column for a nonzero: one in ten falls outside the store, either below
	// the offset or past its end; the rest hit an entry already loaded.
	function automatic logic [15:0] pick_column();
		int pos;
		if ($urandom_range(0, 9) == 0) begin
			if (col_base > 0 && (int'(col_base) + VECTOR_DEPTH > 65535 ||
					$urandom_range(0, 1) != 0))
				return 16'($urandom_range(0, int'(col_base) - 1));
			return 16'($urandom_range(int'(col_base) + VECTOR_DEPTH, 65535));
		end
		pos = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		// entry 0 is always loaded and always reachable
		if (pos + int'(col_base) > 65535)
			pos = 0;
		return 16'(pos + int'(col_base));
	endfunction

	// Random traffic: mostly whole rows with random content, plus loads,
	// empty rows, rows closed by an empty-row item, and dropped items.
	task automatic random_phase(input int quota);
		int counted;
		int n;
		int pick;
		counted = 0;
		while (counted < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				n = $urandom_range(1, 4);
				repeat (n)
					queue_item(ACT_LOAD, 16'($urandom_range(0, VECTOR_DEPTH - 1)),
						rand_q16(), 1'($urandom_range(0, 1)));
				counted += n;
			end else if (pick < 78) begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					queue_item(ACT_NONZERO, pick_column(), rand_q16(), k == n - 1);
				counted += n;
			end else if (pick < 85) begin
				queue_item(ACT_EMPTY, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
				counted++;
			end else if (pick < 92) begin
				// open row, closed by an empty-row item instead of row_end
				n = $urandom_range(1, 3);
				repeat (n)
					queue_item(ACT_NONZERO, pick_column(), rand_q16(), 1'b0);
				queue_item(ACT_EMPTY, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
				counted += n + 1;
			end else if (pick < 96) begin
				// load past the store: dropped
				queue_item(ACT_LOAD, 16'($urandom_range(VECTOR_DEPTH, 65535)), $urandom,
					1'($urandom_range(0, 1)));
			end else begin
				queue_item(ACT_SPARE, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Hold until the stream is drained and every row is back, then let the
	// pipeline settle before touching the register. Check on the falling edge,
	// where the driver's updates have settled.
	task automatic wait_quiet();
		while (item_feed.size() != 0 || item_valid || rows_due.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_column_base(input logic [15:0] base);
		wait_quiet();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= base;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		col_base = base;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, offset at its reset value of zero.
		queue_item(ACT_LOAD, 16'd0, 32'h0001_0000, 1'b0);
		queue_item(ACT_LOAD, 16'd1023, 32'h8000_0000, 1'b0);
		queue_item(ACT_LOAD, 16'd1, 32'h7FFF_FFFF, 1'b0);
		// stray row_end on a load
		queue_item(ACT_LOAD, 16'd2, 32'h0000_0001, 1'b1);
		// load past the store, all bits set
		queue_item(ACT_LOAD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		// 2.5 + max: rounded sum clamps high
		queue_item(ACT_NONZERO, 16'd0, 32'h0002_8000, 1'b0);
		queue_item(ACT_NONZERO, 16'd1, 32'h7FFF_FFFF, 1'b1);
		// exactly half an LSB rounds up; minus half rounds up to zero
		queue_item(ACT_NONZERO, 16'd2, 32'h0000_8000, 1'b1);
		queue_item(ACT_NONZERO, 16'd2, 32'hFFFF_8000, 1'b1);
		// three min-times-min products overflow the accumulator upward
		repeat (2) queue_item(ACT_NONZERO, 16'd1023, 32'h8000_0000, 1'b0);
		queue_item(ACT_NONZERO, 16'd1023, 32'h8000_0000, 1'b1);
		// three max-times-min products overflow it downward
		repeat (2) queue_item(ACT_NONZERO, 16'd1023, 32'h7FFF_FFFF, 1'b0);
		queue_item(ACT_NONZERO, 16'd1023, 32'h7FFF_FFFF, 1'b1);
		// column just past the store, then a good entry closing the row
		queue_item(ACT_NONZERO, 16'd1024, 32'h0001_0000, 1'b0);
		queue_item(ACT_NONZERO, 16'd0, 32'h0001_0000, 1'b1);
		// empty row with stray row_end
		queue_item(ACT_EMPTY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		// open row closed by an empty-row item
		queue_item(ACT_NONZERO, 16'd0, 32'hFFFF_0000, 1'b0);
		queue_item(ACT_EMPTY, 16'd0, 32'd0, 1'b0);
		// unused action does nothing
		queue_item(ACT_SPARE, 16'h1234, 32'h5A5A_A5A5, 1'b1);
		// row of a single bad column still closes
		queue_item(ACT_NONZERO, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);

		random_phase(90);
		set_column_base(16'hFFFF);
		random_phase(110);
		set_column_base(16'($urandom_range(1, 60000)));
		random_phase(130);
		set_column_base(16'hFC00);
		random_phase(130);
		set_column_base(16'h0000);
		random_phase(170);

		// Drain: wait for the last item to go in, then for the rows, bounded.
		while (item_feed.size() != 0 || item_valid)
			@(negedge clk);
		for (int w = 0; w < 20000 && rows_due.size() != 0; w++)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (rows_due.size() != 0) begin
			$error("%0d rows never arrived", rows_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#400000;
		$display("tb: done, errors");
		$finish;
	end

endmodule

// ----- csr_sparse_row_dot_engine_core.f -----
+incdir+hdl
hdl/csrd_pkg.sv
hdl/csrd_fetch.sv
hdl/csrd_mac.sv
hdl/csrd_round.sv
hdl/csr_sparse_row_dot_engine_core.sv
dv/tb.sv
